FILE: rtl/tccs_pkg.sv
// Shared constants, register map and configuration type for the text console core.
`default_nettype none
package tccs_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 32;

  localparam int CELL_AW = 12;
  localparam int CELL_W  = 16;

  localparam int COLS_W = 8;
  localparam int ROWS_W = 6;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int PROD_W = COLS_W + ROWS_W;

  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_POS_W = 12;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_ATTR    = 2'd2;

  localparam logic [COLS_W-1:0] COLUMNS_RST = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RST    = 6'd25;
  localparam logic [ATTR_W-1:0] ATTR_RST    = 8'd15;

  localparam logic [CHAR_W-1:0] CODE_NONE    = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
    logic [ATTR_W-1:0] attr;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/tccs_regs.sv
// Configuration register file with clamped screen geometry.
`default_nettype none
module tccs_regs #(
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tccs_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tccs_pkg::CFG_DW-1:0] pwdata,
  output logic      [tccs_pkg::CFG_DW-1:0] prdata,
  output tccs_pkg::cfg_t                   cfg
);

  logic [tccs_pkg::COLS_W-1:0] cols_r;
  logic [tccs_pkg::ROWS_W-1:0] rows_r;
  logic [tccs_pkg::ATTR_W-1:0] attr_r;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= tccs_pkg::COLUMNS_RST;
      rows_r <= tccs_pkg::ROWS_RST;
      attr_r <= tccs_pkg::ATTR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        tccs_pkg::REG_COLUMNS: cols_r <= pwdata[tccs_pkg::COLS_W-1:0];
        tccs_pkg::REG_ROWS:    rows_r <= pwdata[tccs_pkg::ROWS_W-1:0];
        tccs_pkg::REG_ATTR:    attr_r <= pwdata[tccs_pkg::ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tccs_pkg::REG_COLUMNS: prdata = tccs_pkg::CFG_DW'(cols_r);
      tccs_pkg::REG_ROWS:    prdata = tccs_pkg::CFG_DW'(rows_r);
      tccs_pkg::REG_ATTR:    prdata = tccs_pkg::CFG_DW'(attr_r);
      default:               prdata = '0;
    endcase
  end

  // clamp geometry: zero acts as one, large values saturate at the maximum
  always_comb begin
    if (cols_r == '0) begin
      cfg.cols = tccs_pkg::COLS_W'(1);
    end else if (9'(cols_r) > 9'(MAX_COLUMNS)) begin
      cfg.cols = tccs_pkg::COLS_W'(MAX_COLUMNS);
    end else begin
      cfg.cols = cols_r;
    end
    if (rows_r == '0) begin
      cfg.rows = tccs_pkg::ROWS_W'(1);
    end else if (7'(rows_r) > 7'(MAX_ROWS)) begin
      cfg.rows = tccs_pkg::ROWS_W'(MAX_ROWS);
    end else begin
      cfg.rows = rows_r;
    end
    cfg.attr = attr_r;
  end

endmodule
`default_nettype wire

FILE: rtl/text_console_cursor_scroll_core.sv
// Top level of the text console: screen memory, cursor, scroll engine and stream ports.
//
//  port group | dir | handshake                  | contents
//  in_        | in  | tvalid/tready              | tuser kind, tdata char_code, cell_index
//  out_       | out | tvalid/tready              | cursor, read cell, scrolled flag
//  cfg_       | in  | psel/penable, pready high  | columns, rows, attribute
//
// A read or an ordinary put is accepted, then does its memory access and result.
// A put that scrolls then copies (rows-1)*columns cells up a row and clears the last
// row of columns cells, one cell per cycle through the single memory write port.
// After reset S_INIT clears every screen memory cell; no request is accepted meanwhile.
// The result stage holds while out_tready is low; in_tready stays low until the block is idle.
`default_nettype none
module text_console_cursor_scroll_core #(
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tccs_pkg::IN_DATA_W-1:0]  in_tdata,  // char_code, cell_index
  input  wire logic                            in_tuser,  // kind
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // cursor_col, cursor_row, cursor_pos, cell_char, cell_attr, scrolled
  output logic      [tccs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tccs_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [tccs_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic      [tccs_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int RN_W  = ROW_W + 1;
  localparam int PW    = tccs_pkg::PROD_W;
  localparam int CW    = PW + 1;
  localparam int AW    = tccs_pkg::CELL_AW;
  localparam int DW    = tccs_pkg::CELL_W;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;

  tccs_pkg::cfg_t cfg;

  logic [2:0]      state_r, state_nxt;
  logic [AW-1:0]   init_cnt_r, init_cnt_nxt;
  logic [CW-1:0]   sc_cnt_r, sc_cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic            kind_r, kind_nxt;
  logic [tccs_pkg::CHAR_W-1:0] code_r, code_nxt;
  logic [PW-1:0]   p0_r, p0_nxt;
  logic [PW-1:0]   p1_r, p1_nxt;
  logic [PW-1:0]   keep_r, keep_nxt;
  logic [tccs_pkg::COLS_W-1:0] sc_cols_r, sc_cols_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [tccs_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [DW-1:0]   mem [DEPTH];
  logic [DW-1:0]   rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [DW-1:0]   mem_wdata;

  logic            go, is_put, is_nl, is_cr, is_ch, wrap, adv, scroll;
  logic [8:0]      col_inc;
  logic [COL_W-1:0] col_new;
  logic [RN_W-1:0] row_next;
  logic [ROW_W-1:0] row_fin;
  logic [PW-1:0]   base;
  logic [CW-1:0]   pos_sum, cell_addr;
  logic [tccs_pkg::CHAR_W-1:0] rd_char, rd_attr;

  tccs_regs #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // cursor update for the held request
  always_comb begin
    go      = !out_valid_r || out_tready;
    is_put  = (kind_r == tccs_pkg::KIND_PUT) && (code_r != tccs_pkg::CODE_NONE);
    is_nl   = is_put && (code_r == tccs_pkg::CODE_NEWLINE);
    is_cr   = is_put && (code_r == tccs_pkg::CODE_RETURN);
    is_ch   = is_put && !is_nl && !is_cr;
    col_inc = 9'(cur_col_r) + 9'd1;
    wrap    = col_inc >= 9'(cfg.cols);
    adv     = is_nl || (is_ch && wrap);
    if (is_nl || is_cr || (is_ch && wrap)) begin
      col_new = '0;
    end else if (is_ch) begin
      col_new = COL_W'(col_inc);
    end else begin
      col_new = cur_col_r;
    end
    row_next  = adv ? (RN_W'(cur_row_r) + RN_W'(1)) : RN_W'(cur_row_r);
    scroll    = is_put && (7'(row_next) >= 7'(cfg.rows));
    row_fin   = scroll ? ROW_W'(cfg.rows - 6'd1) : ROW_W'(row_next);
    base      = scroll ? keep_r : (adv ? p1_r : p0_r);
    pos_sum   = CW'(base) + CW'(col_new);
    cell_addr = CW'(p0_r) + CW'(cur_col_r);
    rd_char   = rd_data_r[7:0];
    rd_attr   = rd_data_r[15:8];
  end

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    sc_cnt_nxt    = sc_cnt_r;
    pend_nxt      = pend_r;
    wr_idx_nxt    = wr_idx_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    kind_nxt      = kind_r;
    code_nxt      = code_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    keep_nxt      = keep_r;
    sc_cols_nxt   = sc_cols_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    unique case (state_r)
      S_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = init_cnt_r;
        init_cnt_nxt = init_cnt_r + AW'(1);
        if (init_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt    = in_tuser;
          code_nxt    = in_tdata[7:0];
          p0_nxt      = PW'(PW'(cur_row_r) * PW'(cfg.cols));
          p1_nxt      = PW'(PW'(cur_row_r) * PW'(cfg.cols)) + PW'(cfg.cols);
          keep_nxt    = PW'(PW'(cfg.rows - 6'd1) * PW'(cfg.cols));
          sc_cols_nxt = cfg.cols;
          if (in_tuser == tccs_pkg::KIND_READ) begin
            mem_re    = 1'b1;
            mem_raddr = in_tdata[19:8];
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          if (is_put) begin
            cur_col_nxt  = col_new;
            cur_row_nxt  = row_fin;
            out_data_nxt = {7'd0, scroll, 8'd0, 8'd0, pos_sum[11:0],
                            tccs_pkg::OUT_ROW_W'(row_fin), tccs_pkg::OUT_COL_W'(col_new)};
          end else if (kind_r == tccs_pkg::KIND_READ) begin
            out_data_nxt = {7'd0, 1'b0, rd_attr, rd_char, cell_addr[11:0],
                            tccs_pkg::OUT_ROW_W'(cur_row_r), tccs_pkg::OUT_COL_W'(cur_col_r)};
          end else begin
            out_data_nxt = {7'd0, 1'b0, 8'd0, 8'd0, cell_addr[11:0],
                            tccs_pkg::OUT_ROW_W'(cur_row_r), tccs_pkg::OUT_COL_W'(cur_col_r)};
          end
          if (is_ch) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr[AW-1:0];
            mem_wdata = {cfg.attr, code_r};
          end
          if (scroll) begin
            sc_cnt_nxt = '0;
            pend_nxt   = 1'b0;
            state_nxt  = S_COPY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_COPY: begin
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = rd_data_r;
        end
        if (sc_cnt_r < CW'(keep_r)) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(sc_cnt_r + CW'(sc_cols_r));
          pend_nxt   = 1'b1;
          wr_idx_nxt = AW'(sc_cnt_r);
          sc_cnt_nxt = sc_cnt_r + CW'(1);
        end else begin
          pend_nxt   = 1'b0;
          sc_cnt_nxt = CW'(keep_r);
          state_nxt  = S_FILL;
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(sc_cnt_r);
        sc_cnt_nxt = sc_cnt_r + CW'(1);
        if (sc_cnt_r + CW'(1) == CW'(keep_r) + CW'(sc_cols_r)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      sc_cnt_r    <= '0;
      pend_r      <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      sc_cnt_r    <= sc_cnt_nxt;
      pend_r      <= pend_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r   <= wr_idx_nxt;
    kind_r     <= kind_nxt;
    code_r     <= code_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    keep_r     <= keep_nxt;
    sc_cols_r  <= sc_cols_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < MAX_ROWS)
    else $error("cursor row beyond maximum");

  a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) && mem_re && mem_we |-> mem_raddr != mem_waddr)
    else $error("scroll copy reads the cell it writes");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result raised outside execute");

endmodule
`default_nettype wire

FILE: test/text_console_cursor_scroll_core_tb.sv
// Testbench for the text console core: request streams, cursor and screen predictor, result checks.
`timescale 1ns / 100ps
module text_console_cursor_scroll_core_tb;
  import tccs_pkg::*;

  localparam int CELLS        = 1 << CELL_AW;
  localparam int LIMIT_CYCLES = 20_000_000;

  typedef struct packed {
    logic [6:0]           pad;
    logic                 scrolled;
    logic [ATTR_W-1:0]    attr;
    logic [CHAR_W-1:0]    ch;
    logic [OUT_POS_W-1:0] pos;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } console_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int                cur_col;
  int                cur_row;
  logic [COLS_W-1:0] cols_reg;
  logic [ROWS_W-1:0] rows_reg;
  logic [ATTR_W-1:0] attr_reg;

  console_result_t expected_results [$];
  int              mismatch_count;
  int              cycle_count;
  bit              no_idle;

  text_console_cursor_scroll_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // char_code, cell_index
    .in_tuser    (in_tuser),     // kind
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // cursor_col, cursor_row, cursor_pos, cell_char, cell_attr, scrolled
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("text_console_cursor_scroll_core_tb failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 29);
  end

  function automatic int eff_columns();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return cols_reg;
  endfunction

  function automatic int eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return rows_reg;
  endfunction

  task automatic scroll_screen(input int cols, input int rows);
    int keep;
    keep = (rows - 1) * cols;
    for (int i = 0; i < keep; i++) screen_mem[i % CELLS] = screen_mem[(i + cols) % CELLS];
    for (int i = keep; i < keep + cols; i++) screen_mem[i % CELLS] = '0;
  endtask

  // Advance the cursor and screen for one request and queue its result.
  task automatic predict_console(input logic kind, input logic [7:0] code,
                                 input logic [11:0] idx);
    int              cols;
    int              rows;
    console_result_t r;
    cols = eff_columns();
    rows = eff_rows();
    r = '0;
    if (kind == KIND_READ) begin
      r.ch   = screen_mem[idx][7:0];
      r.attr = screen_mem[idx][15:8];
    end else if (code != CODE_NONE) begin
      if (code == CODE_NEWLINE) begin
        cur_row++;
        cur_col = 0;
      end else if (code == CODE_RETURN) begin
        cur_col = 0;
      end else begin
        screen_mem[(cur_row * cols + cur_col) % CELLS] = {attr_reg, code};
        cur_col++;
        if (cur_col >= cols) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row >= rows) begin
        scroll_screen(cols, rows);
        cur_row = rows - 1;
        r.scrolled = 1'b1;
      end
    end
    r.col = cur_col[OUT_COL_W-1:0];
    r.row = cur_row[OUT_ROW_W-1:0];
    r.pos = 12'((cur_row * cols + cur_col) % CELLS);
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("cursor_col", want.col, got.col);
        check_field("cursor_row", want.row, got.row);
        check_field("cursor_pos", want.pos, got.pos);
        check_field("cell_char", want.ch, got.ch);
        check_field("cell_attr", want.attr, got.attr);
        check_field("scrolled", want.scrolled, got.scrolled);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] code, input logic [11:0] idx);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, idx, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_console(kind, code, idx);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] reg_index, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (reg_index)
      REG_COLUMNS: cols_reg = value[COLS_W-1:0];
      REG_ROWS:    rows_reg = value[ROWS_W-1:0];
      REG_ATTR:    attr_reg = value[ATTR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input int cols, input int rows, input int attr);
    wait_results_drained();
    write_register(REG_COLUMNS, cols);
    write_register(REG_ROWS, rows);
    write_register(REG_ATTR, attr);
  endtask

  task automatic send_random_text_item();
    int          pick;
    int          span;
    logic [7:0]  code;
    logic [11:0] idx;
    pick = $urandom_range(99);
    span = eff_columns() * eff_rows();
    if (pick < 16) begin
      if ($urandom_range(2) == 0) idx = 12'($urandom);
      else idx = 12'($urandom_range(span - 1));
      send_item(KIND_READ, 8'($urandom), idx);
    end else begin
      if (pick < 24) code = CODE_NEWLINE;
      else if (pick < 28) code = CODE_RETURN;
      else if (pick < 30) code = CODE_NONE;
      else if (pick < 90) code = 8'($urandom_range(126, 32));
      else code = 8'($urandom_range(255, 1));
      send_item(KIND_PUT, code, 12'($urandom));
    end
  endtask

  task automatic test_reset_state();
    send_item(KIND_READ, 8'h00, 12'd0);
    send_item(KIND_READ, 8'hFF, 12'hFFF);
    send_item(KIND_PUT, "A", 12'd0);
    send_item(KIND_PUT, CODE_NONE, 12'hFFF);
    send_item(KIND_PUT, 8'hFF, 12'd0);
    send_item(KIND_PUT, CODE_RETURN, 12'd0);
    send_item(KIND_PUT, CODE_NEWLINE, 12'd0);
    send_item(KIND_PUT, "B", 12'd0);
    send_item(KIND_READ, 8'h00, 12'd0);
    send_item(KIND_READ, 8'h00, 12'd80);
  endtask

  task automatic test_clamped_geometry();
    set_geometry(0, 0, 0);
    send_item(KIND_PUT, "x", 12'd0);
    send_item(KIND_READ, 8'h00, 12'd0);
    send_item(KIND_PUT, CODE_NEWLINE, 12'd0);
    set_geometry(255, 63, 255);
    send_item(KIND_PUT, 8'h7F, 12'd0);
    send_item(KIND_READ, 8'h00, 12'd0);
    send_item(KIND_PUT, CODE_NEWLINE, 12'd0);
    send_item(KIND_PUT, CODE_RETURN, 12'd0);
  endtask

  task automatic test_reduced_limits();
    set_geometry(128, 32, 8'hA5);
    repeat (3) send_item(KIND_PUT, CODE_NEWLINE, 12'd0);
    send_item(KIND_PUT, "q", 12'd0);
    send_item(KIND_PUT, "r", 12'd0);
    set_geometry(1, 2, 8'h5A);
    send_item(KIND_PUT, "z", 12'd0);
    send_item(KIND_PUT, CODE_NEWLINE, 12'd0);
    send_item(KIND_READ, 8'h00, 12'd0);
  endtask

  task automatic test_random_text(input int count, input int cols, input int rows,
                                  input int attr, input bit steady, input bit pause_midway);
    set_geometry(cols, rows, attr);
    no_idle = steady;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_results_drained();
      send_random_text_item();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    cur_col        = 0;
    cur_row        = 0;
    cols_reg       = COLUMNS_RST;
    rows_reg       = ROWS_RST;
    attr_reg       = ATTR_RST;
    foreach (screen_mem[i]) screen_mem[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_clamped_geometry();
    test_reduced_limits();
    test_random_text(150, 16, 6, $urandom_range(255), 1'b0, 1'b0);
    test_random_text(80, 1, 1, $urandom_range(255), 1'b0, 1'b0);
    test_random_text(150, 7, 3, $urandom_range(255), 1'b1, 1'b0);
    test_random_text(150, $urandom_range(20, 1), $urandom_range(10, 1),
                     $urandom_range(255), 1'b0, 1'b1);
    test_random_text(100, 128, 32, $urandom_range(255), 1'b0, 1'b0);
    test_random_text(60, 255, 63, $urandom_range(255), 1'b0, 1'b0);
    repeat (4) begin
      test_random_text(100, $urandom_range(24, 1), $urandom_range(12, 1),
                       $urandom_range(255), 1'b0, 1'b0);
    end
    test_random_text(100, COLUMNS_RST, ROWS_RST, ATTR_RST, 1'b0, 1'b0);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_cursor_scroll_core_tb passed");
    end else begin
      $display("text_console_cursor_scroll_core_tb failed");
    end
    $finish;
  end

endmodule
